// ===== rtl/core/mcr_pkg.sv =====
// Shared constants and helpers for the midpoint circle rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package mcr_pkg;

   localparam int DEFAULT_MAX_RADIUS = 1023;
   localparam int DEFAULT_COORD_BITS = 16;

   localparam int PORT_COORD_BITS = 16;
   localparam int COLOR_BITS      = 16;
   localparam int RADIUS_BITS     = 10;

   localparam int QUEUE_DEPTH = 2;

   // decision update constants
   localparam int DEC_INIT     = 3;
   localparam int DEC_STEP     = 4;
   localparam int DEC_INC_DIAG = 10;
   localparam int DEC_INC_AXIS = 6;

   // result index within a set
   localparam int SET_IDX_BITS = 3;
   localparam logic [SET_IDX_BITS-1:0] OUTLINE_LAST = 3'd7;
   localparam logic [SET_IDX_BITS-1:0] FILL_LAST    = 3'd3;

   typedef enum logic {
      OP_START   = 1'b0,
      OP_ADVANCE = 1'b1
   } op_type;

   // signed offset width: radius bits plus sign
   function automatic int ofs_bits(input int max_radius);
      ofs_bits = $clog2(max_radius + 1) + 1;
   endfunction

   // decision value stays within three bits above the offset width
   function automatic int dec_bits(input int max_radius);
      dec_bits = ofs_bits(max_radius) + 3;
   endfunction

   function automatic int desc_bits(input int max_radius, input int coord_bits);
      desc_bits = 2 * coord_bits + 2 * ofs_bits(max_radius) + COLOR_BITS + 2;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mcr_fifo.sv =====
// Small register queue between the step unit and the set emitter.
`timescale 1ns / 1ps
`default_nettype none

module mcr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                do_push, do_pop;

   assign full     = (count_ff == CNT_FULL);
   assign empty    = (count_ff == '0);
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mcr_stepper.sv =====
// Front end: takes start/advance beats, runs the midpoint iteration, queues one set.
`timescale 1ns / 1ps
`default_nettype none

module mcr_stepper import mcr_pkg::*; #(
   parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS,
   parameter int COORD_BITS = DEFAULT_COORD_BITS,
   parameter int DESC_BITS  = desc_bits(MAX_RADIUS, COORD_BITS)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   input  wire logic                       queue_full,
   input  wire logic                       req_operation,
   input  wire logic [PORT_COORD_BITS-1:0] req_center_x,
   input  wire logic [PORT_COORD_BITS-1:0] req_center_y,
   input  wire logic [RADIUS_BITS-1:0]     req_radius,
   input  wire logic [COLOR_BITS-1:0]      req_color,
   input  wire logic                       req_filled,
   output logic                            set_push,
   output logic [DESC_BITS-1:0]            set_desc
);

   localparam int OFS_BITS = ofs_bits(MAX_RADIUS);
   localparam int RAD_BITS = OFS_BITS - 1;
   localparam int DEC_BITS = dec_bits(MAX_RADIUS);

   typedef struct packed {
      logic [COORD_BITS-1:0]      cx;
      logic [COORD_BITS-1:0]      cy;
      logic signed [OFS_BITS-1:0] a;
      logic signed [OFS_BITS-1:0] b;
      logic [COLOR_BITS-1:0]      color;
      logic                       fill;
      logic                       done;
   } desc_type;

   logic signed [OFS_BITS-1:0] a_ff, a_in;
   logic signed [OFS_BITS-1:0] b_ff, b_in;
   logic signed [DEC_BITS-1:0] dec_ff, dec_in;
   logic [COORD_BITS-1:0]      cx_ff, cx_in;
   logic [COORD_BITS-1:0]      cy_ff, cy_in;
   logic [COLOR_BITS-1:0]      color_ff, color_in;
   logic                       fill_ff, fill_in;
   logic                       active_ff, active_in;

   logic                       accept, is_start;
   logic [RAD_BITS-1:0]        r_sat;
   logic signed [OFS_BITS-1:0] a_step, b_step;
   logic signed [OFS_BITS:0]   diff;
   logic signed [DEC_BITS-1:0] dec_step;
   logic                       dec_pos, done;
   desc_type                   desc;

   assign accept   = req_push && !queue_full;
   assign is_start = (req_operation == OP_START);

   assign r_sat = (32'(req_radius) > 32'(MAX_RADIUS)) ? RAD_BITS'(MAX_RADIUS)
                                                      : RAD_BITS'(req_radius);

   // one midpoint iteration from the held state
   assign dec_pos = !dec_ff[DEC_BITS-1] && (dec_ff != '0);
   assign a_step  = a_ff + OFS_BITS'(1);
   assign b_step  = dec_pos ? b_ff - OFS_BITS'(1) : b_ff;
   assign diff    = (OFS_BITS+1)'(a_step) - (OFS_BITS+1)'(b_step);
   assign dec_step = dec_pos
      ? dec_ff + DEC_BITS'(DEC_BITS'(diff) * DEC_BITS'(DEC_STEP)) + DEC_BITS'(DEC_INC_DIAG)
      : dec_ff + DEC_BITS'(DEC_BITS'(a_step) * DEC_BITS'(DEC_STEP)) + DEC_BITS'(DEC_INC_AXIS);

   always_comb begin
      a_in      = a_ff;
      b_in      = b_ff;
      dec_in    = dec_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      color_in  = color_ff;
      fill_in   = fill_ff;
      if (is_start) begin
         a_in     = '0;
         b_in     = OFS_BITS'(r_sat);
         dec_in   = DEC_BITS'(DEC_INIT) - DEC_BITS'({r_sat, 1'b0});
         cx_in    = COORD_BITS'(req_center_x);
         cy_in    = COORD_BITS'(req_center_y);
         color_in = req_color;
         fill_in  = req_filled;
      end else begin
         a_in   = a_step;
         b_in   = b_step;
         dec_in = dec_step;
      end
   end

   assign done      = (b_in < a_in);
   assign set_push  = accept && (is_start || active_ff);
   assign active_in = !done;

   assign desc.cx    = cx_in;
   assign desc.cy    = cy_in;
   assign desc.a     = a_in;
   assign desc.b     = b_in;
   assign desc.color = color_in;
   assign desc.fill  = fill_in;
   assign desc.done  = done;
   assign set_desc   = desc;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else if (set_push) begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      if (set_push) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         dec_ff   <= dec_in;
         cx_ff    <= cx_in;
         cy_ff    <= cy_in;
         color_ff <= color_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/mcr_emitter.sv =====
// Back end: expands one queued set into points or spans, one beat per cycle unless the output is held.
`timescale 1ns / 1ps
`default_nettype none

module mcr_emitter import mcr_pkg::*; #(
   parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS,
   parameter int COORD_BITS = DEFAULT_COORD_BITS,
   parameter int DESC_BITS  = desc_bits(MAX_RADIUS, COORD_BITS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  queue_empty,
   input  wire logic [DESC_BITS-1:0]  queue_desc,
   output logic                       queue_pop,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [PORT_COORD_BITS-1:0] rsp_x_start,
   output logic [PORT_COORD_BITS-1:0] rsp_x_end,
   output logic [PORT_COORD_BITS-1:0] rsp_row,
   output logic [COLOR_BITS-1:0]      rsp_pixel_color,
   output logic                       rsp_last_of_set,
   output logic                       rsp_finished
);

   localparam int OFS_BITS = ofs_bits(MAX_RADIUS);

   typedef struct packed {
      logic [COORD_BITS-1:0]      cx;
      logic [COORD_BITS-1:0]      cy;
      logic signed [OFS_BITS-1:0] a;
      logic signed [OFS_BITS-1:0] b;
      logic [COLOR_BITS-1:0]      color;
      logic                       fill;
      logic                       done;
   } desc_type;

   desc_type                work_ff, work_in;
   logic                    work_valid_ff, work_valid_in;
   logic [SET_IDX_BITS-1:0] idx_ff, idx_in;
   logic                    out_valid_ff, out_valid_in;
   logic [COORD_BITS-1:0]   xs_ff, xs_in;
   logic [COORD_BITS-1:0]   xe_ff, xe_in;
   logic [COORD_BITS-1:0]   row_ff, row_in;
   logic [COLOR_BITS-1:0]   color_ff;
   logic                    last_ff, last_in;
   logic                    fin_ff;

   logic                       out_ready, advance, load;
   logic                       swap, x_neg, y_neg;
   logic signed [OFS_BITS-1:0] h_ofs, v_ofs;
   logic [COORD_BITS-1:0]      hc, vc, x_plus, x_minus;

   assign out_ready = !out_valid_ff || rsp_pop;
   assign advance   = work_valid_ff && out_ready;
   assign last_in   = work_ff.fill ? (idx_ff == FILL_LAST) : (idx_ff == OUTLINE_LAST);
   assign load      = !work_valid_ff || (advance && last_in);
   assign queue_pop = load && !queue_empty;

   // point/span geometry for the current index
   assign swap  = work_ff.fill ? idx_ff[0] : idx_ff[2];
   assign x_neg = idx_ff[0];
   assign y_neg = idx_ff[1];
   assign h_ofs = swap ? work_ff.b : work_ff.a;
   assign v_ofs = swap ? work_ff.a : work_ff.b;
   assign hc    = COORD_BITS'(h_ofs);
   assign vc    = COORD_BITS'(v_ofs);
   assign x_plus  = work_ff.cx + hc;
   assign x_minus = work_ff.cx - hc;
   assign row_in  = y_neg ? work_ff.cy - vc : work_ff.cy + vc;

   always_comb begin
      if (work_ff.fill) begin
         xs_in = x_minus;
         xe_in = x_plus;
      end else begin
         xs_in = x_neg ? x_minus : x_plus;
         xe_in = xs_in;
      end
   end

   always_comb begin
      work_in       = work_ff;
      work_valid_in = work_valid_ff;
      idx_in        = idx_ff;
      if (load) begin
         work_in       = queue_desc;
         work_valid_in = !queue_empty;
         idx_in        = '0;
      end else if (advance) begin
         idx_in = idx_ff + SET_IDX_BITS'(1);
      end
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         idx_ff        <= '0;
      end else begin
         work_valid_ff <= work_valid_in;
         out_valid_ff  <= out_valid_in;
         idx_ff        <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff <= work_in;
      if (advance) begin
         xs_ff    <= xs_in;
         xe_ff    <= xe_in;
         row_ff   <= row_in;
         color_ff <= work_ff.color;
         last_ff  <= last_in;
         fin_ff   <= work_ff.done;
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_x_start     = PORT_COORD_BITS'(xs_ff);
   assign rsp_x_end       = PORT_COORD_BITS'(xe_ff);
   assign rsp_row         = PORT_COORD_BITS'(row_ff);
   assign rsp_pixel_color = color_ff;
   assign rsp_last_of_set = last_ff;
   assign rsp_finished    = fin_ff;

endmodule

`default_nettype wire

// ===== rtl/core/midpoint_circle_rasterizer.sv =====
// Midpoint circle rasterizer: stepper, set queue and point/span emitter.
// A beat's set is written to the queue, loaded into the emitter's work register, then registered at the output.
// Throughput: one result per cycle from the emitter's output register while rsp_pop keeps up; an outline
// set gives 8 results and a filled set 4; the step unit runs one iteration per beat.
// Advance beats with no circle in progress are accepted and produce nothing.
// Reset (synchronous) empties the queue and output and clears the in-progress flag.
`timescale 1ns / 1ps
`default_nettype none

module midpoint_circle_rasterizer import mcr_pkg::*; #(
   parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS,
   parameter int COORD_BITS = DEFAULT_COORD_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_push,
   output logic                            req_full,
   input  wire logic                       req_operation,
   input  wire logic [PORT_COORD_BITS-1:0] req_center_x,
   input  wire logic [PORT_COORD_BITS-1:0] req_center_y,
   input  wire logic [RADIUS_BITS-1:0]     req_radius,
   input  wire logic [COLOR_BITS-1:0]      req_color,
   input  wire logic                       req_filled,
   output logic                            rsp_empty,
   input  wire logic                       rsp_pop,
   output logic [PORT_COORD_BITS-1:0]      rsp_x_start,
   output logic [PORT_COORD_BITS-1:0]      rsp_x_end,
   output logic [PORT_COORD_BITS-1:0]      rsp_row,
   output logic [COLOR_BITS-1:0]           rsp_pixel_color,
   output logic                            rsp_last_of_set,
   output logic                            rsp_finished
);

   localparam int DESC_BITS = desc_bits(MAX_RADIUS, COORD_BITS);

   logic                 set_push, queue_pop, queue_empty;
   logic [DESC_BITS-1:0] set_desc, queue_desc;

   mcr_stepper #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS),
      .DESC_BITS  (DESC_BITS)
   ) u_stepper (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .queue_full    (req_full),
      .req_operation (req_operation),
      .req_center_x  (req_center_x),
      .req_center_y  (req_center_y),
      .req_radius    (req_radius),
      .req_color     (req_color),
      .req_filled    (req_filled),
      .set_push      (set_push),
      .set_desc      (set_desc)
   );

   mcr_fifo #(
      .WIDTH (DESC_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (set_push),
      .push_data (set_desc),
      .full      (req_full),
      .pop       (queue_pop),
      .pop_data  (queue_desc),
      .empty     (queue_empty)
   );

   mcr_emitter #(
      .MAX_RADIUS (MAX_RADIUS),
      .COORD_BITS (COORD_BITS),
      .DESC_BITS  (DESC_BITS)
   ) u_emitter (
      .clock           (clock),
      .reset           (reset),
      .queue_empty     (queue_empty),
      .queue_desc      (queue_desc),
      .queue_pop       (queue_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_x_start     (rsp_x_start),
      .rsp_x_end       (rsp_x_end),
      .rsp_row         (rsp_row),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last_of_set (rsp_last_of_set),
      .rsp_finished    (rsp_finished)
   );

endmodule

`default_nettype wire
